>>> rtl/core/eapc_pkg.sv
// Shared constants and types for the ellipse arc pixel classifier.
// Depends on nothing; the other files in rtl/core that use it refer to it by scoped names.
`default_nettype none

package eapc_pkg;

	// Field widths of the pixel channel and the register file
	localparam int unsigned COORD_WIDTH_DEF = 16;
	localparam int unsigned OFFSET_W        = 16;
	localparam int unsigned RADIUS_W        = 15;
	localparam int unsigned DIR_W           = 17;
	localparam int unsigned MODE_W          = 2;

	// Register port geometry
	localparam int unsigned APB_AW = 5;
	localparam int unsigned APB_DW = 32;
	localparam int unsigned IDX_W  = 3;

	// Register index, taken from the word address
	typedef enum logic [IDX_W-1:0] {
		REG_RADIUS_X = 3'd0,
		REG_RADIUS_Y = 3'd1,
		REG_START_DX = 3'd2,
		REG_START_DY = 3'd3,
		REG_END_DX   = 3'd4,
		REG_END_DY   = 3'd5,
		REG_ARC_MODE = 3'd6
	} reg_idx_t;

	// Arc mode codes; the spare code behaves as the whole-ellipse mode
	localparam logic [MODE_W-1:0] MODE_WHOLE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ARC_FULL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ARC_RAY  = 2'd2;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic        [RADIUS_W-1:0] radius_x;
		logic        [RADIUS_W-1:0] radius_y;
		logic signed [DIR_W-1:0]    start_dx;
		logic signed [DIR_W-1:0]    start_dy;
		logic signed [DIR_W-1:0]    end_dx;
		logic signed [DIR_W-1:0]    end_dy;
		logic        [MODE_W-1:0]   arc_mode;
	} cfg_t;

	// Per-stage load enables handed to the datapath slices
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} adv_t;

endpackage

`default_nettype wire

>>> rtl/core/eapc_pix_if.sv
// Pixel offset channel: valid/ready handshake with the two centre offsets.
// Depends on eapc_pkg for the field width.
`default_nettype none

interface eapc_pix_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [eapc_pkg::OFFSET_W-1:0] offset_x;
	logic signed [eapc_pkg::OFFSET_W-1:0] offset_y;

	modport source (output valid, output offset_x, output offset_y, input ready);
	modport sink   (input valid, input offset_x, input offset_y, output ready);
endinterface

`default_nettype wire

>>> rtl/core/eapc_flag_if.sv
// Result channel: valid/ready handshake with the three classification flags.
// No dependencies.
`default_nettype none

interface eapc_flag_if;
	logic valid;
	logic ready;
	logic inside_res;
	logic on_border;
	logic in_arc;

	modport source (output valid, output inside_res, output on_border, output in_arc,
		input ready);
	modport sink   (input valid, input inside_res, input on_border, input in_arc,
		output ready);
endinterface

`default_nettype wire

>>> rtl/core/eapc_inside.sv
// Ellipse membership datapath: three register stages testing a pixel and its
// four neighbours exactly. Depends on eapc_pkg (cfg_t, adv_t, widths).
`default_nettype none

module eapc_inside #(
	parameter int unsigned COORD_WIDTH = eapc_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire eapc_pkg::adv_t                adv,
	input  wire eapc_pkg::cfg_t                cfg,
	input  wire logic signed [COORD_WIDTH-1:0] dx,
	input  wire logic signed [COORD_WIDTH-1:0] dy,
	output logic                         [4:0] ins_s3
);

	localparam int unsigned RW   = eapc_pkg::RADIUS_W;
	localparam int unsigned XW   = COORD_WIDTH + 1;
	localparam int unsigned MW   = COORD_WIDTH;
	localparam int unsigned UW   = MW + RW;
	localparam int unsigned SW   = 2 * UW;
	localparam int unsigned WW   = 2 * RW;
	localparam int unsigned W2   = 2 * WW;
	localparam int unsigned CMPW = ((SW > W2) ? SW : W2) + 1;
	localparam logic signed [XW-1:0] ONE = XW'(1);

	function automatic logic [MW-1:0] mag(input logic signed [XW-1:0] v);
		logic [XW-1:0] n;
		n = v[XW-1] ? -v : v;
		return n[MW-1:0];
	endfunction

	// Membership when a semi-axis is zero: a point or an axis segment
	function automatic logic deg_in(input logic [MW-1:0] ax, input logic [MW-1:0] ay,
		input logic [RW-1:0] rx, input logic [RW-1:0] ry);
		logic r;
		logic ax_le;
		logic ay_le;
		ax_le = {{RW{1'b0}}, ax} <= {{MW{1'b0}}, rx};
		ay_le = {{RW{1'b0}}, ay} <= {{MW{1'b0}}, ry};
		priority if (rx == '0 && ry == '0) begin
			r = (ax == '0) && (ay == '0);
		end else if (rx == '0) begin
			r = (ax == '0) && ay_le;
		end else begin
			r = (ay == '0) && ax_le;
		end
		return r;
	endfunction

	logic signed [XW-1:0] x0, xm, xp, y0, ym, yp;
	logic [MW-1:0] ma0, mam, map, mb0, mbm, mbp;

	logic [UW-1:0] ua0_s1, uam_s1, uap_s1, vb0_s1, vbm_s1, vbp_s1;
	logic [WW-1:0] w_s1;
	logic [4:0]    dins_s1;
	logic          deg_s1;

	logic [SW-1:0] sa0_s2, sam_s2, sap_s2, sb0_s2, sbm_s2, sbp_s2;
	logic [W2-1:0] w2_s2;
	logic [4:0]    dins_s2;
	logic          deg_s2;

	logic [CMPW-1:0] lim;
	logic [4:0]      fit;

	// Neighbour coordinates at full width and their magnitudes
	always_comb begin
		x0  = {dx[COORD_WIDTH-1], dx};
		y0  = {dy[COORD_WIDTH-1], dy};
		xm  = x0 - ONE;
		xp  = x0 + ONE;
		ym  = y0 - ONE;
		yp  = y0 + ONE;
		ma0 = mag(x0);
		mam = mag(xm);
		map = mag(xp);
		mb0 = mag(y0);
		mbm = mag(ym);
		mbp = mag(yp);
	end

	// Stage 1: scale each magnitude by the opposite semi-axis
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			ua0_s1  <= UW'(ma0) * UW'(cfg.radius_y);
			uam_s1  <= UW'(mam) * UW'(cfg.radius_y);
			uap_s1  <= UW'(map) * UW'(cfg.radius_y);
			vb0_s1  <= UW'(mb0) * UW'(cfg.radius_x);
			vbm_s1  <= UW'(mbm) * UW'(cfg.radius_x);
			vbp_s1  <= UW'(mbp) * UW'(cfg.radius_x);
			w_s1    <= WW'(cfg.radius_x) * WW'(cfg.radius_y);
			deg_s1  <= (cfg.radius_x == '0) || (cfg.radius_y == '0);
			dins_s1 <= {deg_in(ma0, mbp, cfg.radius_x, cfg.radius_y),
				deg_in(ma0, mbm, cfg.radius_x, cfg.radius_y),
				deg_in(map, mb0, cfg.radius_x, cfg.radius_y),
				deg_in(mam, mb0, cfg.radius_x, cfg.radius_y),
				deg_in(ma0, mb0, cfg.radius_x, cfg.radius_y)};
		end
	end

	// Stage 2: square the scaled terms and the bound
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			sa0_s2  <= SW'(ua0_s1) * SW'(ua0_s1);
			sam_s2  <= SW'(uam_s1) * SW'(uam_s1);
			sap_s2  <= SW'(uap_s1) * SW'(uap_s1);
			sb0_s2  <= SW'(vb0_s1) * SW'(vb0_s1);
			sbm_s2  <= SW'(vbm_s1) * SW'(vbm_s1);
			sbp_s2  <= SW'(vbp_s1) * SW'(vbp_s1);
			w2_s2   <= W2'(w_s1) * W2'(w_s1);
			dins_s2 <= dins_s1;
			deg_s2  <= deg_s1;
		end
	end

	// Sum and compare against the bound for centre, left, right, up, down
	always_comb begin
		lim    = CMPW'(w2_s2);
		fit[0] = (CMPW'(sa0_s2) + CMPW'(sb0_s2)) <= lim;
		fit[1] = (CMPW'(sam_s2) + CMPW'(sb0_s2)) <= lim;
		fit[2] = (CMPW'(sap_s2) + CMPW'(sb0_s2)) <= lim;
		fit[3] = (CMPW'(sa0_s2) + CMPW'(sbm_s2)) <= lim;
		fit[4] = (CMPW'(sa0_s2) + CMPW'(sbp_s2)) <= lim;
	end

	// Stage 3: pick the degenerate answer when a semi-axis is zero
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			ins_s3 <= deg_s2 ? dins_s2 : fit;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/eapc_sector.sv
// Arc sector datapath: three register stages of cross and dot products that
// place a pixel direction against the start and end directions. Depends on eapc_pkg.
`default_nettype none

module eapc_sector #(
	parameter int unsigned COORD_WIDTH = eapc_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire eapc_pkg::adv_t                adv,
	input  wire eapc_pkg::cfg_t                cfg,
	input  wire logic signed [COORD_WIDTH-1:0] dx,
	input  wire logic signed [COORD_WIDTH-1:0] dy,
	output logic                               in_arc_s3
);

	localparam int unsigned DW   = eapc_pkg::DIR_W + 1;
	localparam int unsigned PW   = COORD_WIDTH + 1;
	localparam int unsigned PRW  = DW + PW;
	localparam int unsigned CPW  = PRW + 1;
	localparam int unsigned ERW  = 2 * DW;
	localparam int unsigned CEW  = ERW + 1;

	function automatic logic lower_dir(input logic signed [DW-1:0] x,
		input logic signed [DW-1:0] y);
		return y[DW-1] || ((y == '0) && x[DW-1]);
	endfunction

	function automatic logic lower_pix(input logic signed [PW-1:0] x,
		input logic signed [PW-1:0] y);
		return y[PW-1] || ((y == '0) && x[PW-1]);
	endfunction

	logic signed [DW-1:0] sx, sy, ex, ey;
	logic signed [PW-1:0] px, py;

	logic signed [PRW-1:0] sp_a_s1, sp_b_s1, pe_a_s1, pe_b_s1, dsp_a_s1, dsp_b_s1;
	logic signed [ERW-1:0] se_a_s1, se_b_s1, dse_a_s1, dse_b_s1;
	logic hs_s1, he_s1, hp_s1, ctr_s1;

	logic signed [CPW-1:0] c_sp, c_pe, d_sp;
	logic signed [CEW-1:0] c_se, d_se;

	logic le_sp_s2, le_pe_s2, le_se_s2, same_se_s2, same_sp_s2, ctr_s2;

	// Directions in y-up orientation; a zero start or end vector points along +x
	always_comb begin
		sx = {cfg.start_dx[eapc_pkg::DIR_W-1], cfg.start_dx};
		sy = -{cfg.start_dy[eapc_pkg::DIR_W-1], cfg.start_dy};
		if (cfg.start_dx == '0 && cfg.start_dy == '0) begin
			sx = DW'(1);
		end
		ex = {cfg.end_dx[eapc_pkg::DIR_W-1], cfg.end_dx};
		ey = -{cfg.end_dy[eapc_pkg::DIR_W-1], cfg.end_dy};
		if (cfg.end_dx == '0 && cfg.end_dy == '0) begin
			ex = DW'(1);
		end
		px = {dx[COORD_WIDTH-1], dx};
		py = -{dy[COORD_WIDTH-1], dy};
	end

	// Stage 1: partial products of every cross and dot product needed
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			sp_a_s1  <= PRW'(sx) * PRW'(py);
			sp_b_s1  <= PRW'(sy) * PRW'(px);
			pe_a_s1  <= PRW'(ey) * PRW'(px);
			pe_b_s1  <= PRW'(ex) * PRW'(py);
			dsp_a_s1 <= PRW'(sx) * PRW'(px);
			dsp_b_s1 <= PRW'(sy) * PRW'(py);
			se_a_s1  <= ERW'(sx) * ERW'(ey);
			se_b_s1  <= ERW'(sy) * ERW'(ex);
			dse_a_s1 <= ERW'(sx) * ERW'(ex);
			dse_b_s1 <= ERW'(sy) * ERW'(ey);
			hs_s1    <= lower_dir(sx, sy);
			he_s1    <= lower_dir(ex, ey);
			hp_s1    <= lower_pix(px, py);
			ctr_s1   <= (dx == '0) && (dy == '0);
		end
	end

	// Combine partial products into cross and dot values
	always_comb begin
		c_sp = CPW'(sp_a_s1) - CPW'(sp_b_s1);
		c_pe = CPW'(pe_a_s1) - CPW'(pe_b_s1);
		d_sp = CPW'(dsp_a_s1) + CPW'(dsp_b_s1);
		c_se = CEW'(se_a_s1) - CEW'(se_b_s1);
		d_se = CEW'(dse_a_s1) + CEW'(dse_b_s1);
	end

	// Stage 2: angular order of start, pixel and end, and equal-direction tests
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			le_sp_s2   <= (hs_s1 != hp_s1) ? !hs_s1 : !c_sp[CPW-1];
			le_pe_s2   <= (hp_s1 != he_s1) ? !hp_s1 : !c_pe[CPW-1];
			le_se_s2   <= (hs_s1 != he_s1) ? !hs_s1 : !c_se[CEW-1];
			same_se_s2 <= (c_se == '0) && !d_se[CEW-1] && (d_se != '0);
			same_sp_s2 <= (c_sp == '0) && !d_sp[CPW-1] && (d_sp != '0);
			ctr_s2     <= ctr_s1;
		end
	end

	// Stage 3: sector decision by mode, with wrap-around when start passes end; other modes take every pixel
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			unique case (cfg.arc_mode)
				eapc_pkg::MODE_ARC_FULL: begin
					if (same_se_s2 || ctr_s2) begin
						in_arc_s3 <= 1'b1;
					end else if (le_se_s2) begin
						in_arc_s3 <= le_sp_s2 && le_pe_s2;
					end else begin
						in_arc_s3 <= le_sp_s2 || le_pe_s2;
					end
				end
				eapc_pkg::MODE_ARC_RAY: begin
					if (same_se_s2) begin
						in_arc_s3 <= !ctr_s2 && same_sp_s2;
					end else if (ctr_s2) begin
						in_arc_s3 <= 1'b1;
					end else if (le_se_s2) begin
						in_arc_s3 <= le_sp_s2 && le_pe_s2;
					end else begin
						in_arc_s3 <= le_sp_s2 || le_pe_s2;
					end
				end
				default: begin
					in_arc_s3 <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ellipse_arc_pixel_classifier_unit.sv
// Ellipse arc pixel classifier, top level: register port, handshake pipeline
// and output register. Depends on eapc_pkg, eapc_pix_if, eapc_flag_if,
// eapc_inside and eapc_sector.
//
// Usage:
//   pix   - sink channel; one transfer carries a pixel offset from the centre.
//   flags - source channel; one transfer per pixel with inside_res, on_border
//           and in_arc, in the order the pixels arrived.
//   APB   - register writes for semi-axes, arc start/end vectors and arc mode;
//           write them only while no pixel is in flight.
// Pipeline: an accepted pixel moves through four stages (scale, square, compare,
//   output) before its flags are offered on flags.valid.
// Throughput: one pixel per cycle while the receiver keeps flags.ready high;
//   a stalled receiver holds the flow, as described below.
// Each stage holds its own valid bit and loads whenever it is empty or the stage
// after it moves, so gaps close up and pix.ready stays high while the output
// register is empty or being drained.
// When the receiver stalls, the output register holds its flags and the stages
// behind it fill up before pix.ready drops; nothing is lost or repeated.
// Reset clears all valid bits and every configuration register to zero
// (whole ellipse mode).
`default_nettype none

module ellipse_arc_pixel_classifier_unit #(
	parameter int unsigned COORD_WIDTH = eapc_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	eapc_pix_if.sink                           pix,
	eapc_flag_if.source                        flags,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [eapc_pkg::APB_AW-1:0]   paddr,
	input  wire logic [eapc_pkg::APB_DW-1:0]   pwdata,
	output logic      [eapc_pkg::APB_DW-1:0]   prdata,
	output logic                               pready
);

	eapc_pkg::cfg_t     cfg_q;
	eapc_pkg::reg_idx_t reg_idx;
	eapc_pkg::adv_t     adv;
	logic               wr_en;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [COORD_WIDTH-1:0] dx, dy;
	logic [4:0] ins_s3;
	logic       in_arc_s3;
	logic       inside_s4, border_s4, arc_s4;

	// Register port: zero wait states, write on the access phase
	assign pready  = 1'b1;
	assign reg_idx = eapc_pkg::reg_idx_t'(paddr[eapc_pkg::APB_AW-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				eapc_pkg::REG_RADIUS_X: cfg_q.radius_x <= pwdata[eapc_pkg::RADIUS_W-1:0];
				eapc_pkg::REG_RADIUS_Y: cfg_q.radius_y <= pwdata[eapc_pkg::RADIUS_W-1:0];
				eapc_pkg::REG_START_DX: cfg_q.start_dx <= pwdata[eapc_pkg::DIR_W-1:0];
				eapc_pkg::REG_START_DY: cfg_q.start_dy <= pwdata[eapc_pkg::DIR_W-1:0];
				eapc_pkg::REG_END_DX:   cfg_q.end_dx   <= pwdata[eapc_pkg::DIR_W-1:0];
				eapc_pkg::REG_END_DY:   cfg_q.end_dy   <= pwdata[eapc_pkg::DIR_W-1:0];
				eapc_pkg::REG_ARC_MODE: cfg_q.arc_mode <= pwdata[eapc_pkg::MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back, signed fields sign-extended
	always_comb begin
		unique case (reg_idx)
			eapc_pkg::REG_RADIUS_X: prdata = eapc_pkg::APB_DW'(cfg_q.radius_x);
			eapc_pkg::REG_RADIUS_Y: prdata = eapc_pkg::APB_DW'(cfg_q.radius_y);
			eapc_pkg::REG_START_DX: prdata = eapc_pkg::APB_DW'(cfg_q.start_dx);
			eapc_pkg::REG_START_DY: prdata = eapc_pkg::APB_DW'(cfg_q.start_dy);
			eapc_pkg::REG_END_DX:   prdata = eapc_pkg::APB_DW'(cfg_q.end_dx);
			eapc_pkg::REG_END_DY:   prdata = eapc_pkg::APB_DW'(cfg_q.end_dy);
			eapc_pkg::REG_ARC_MODE: prdata = eapc_pkg::APB_DW'(cfg_q.arc_mode);
			default:                prdata = '0;
		endcase
	end

	// Stage loads: a stage advances when empty or when its successor advances
	assign rdy4      = !v_s4 || flags.ready;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign pix.ready = rdy1;
	assign adv.s1    = rdy1;
	assign adv.s2    = rdy2;
	assign adv.s3    = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= pix.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Keep the low coordinate bits; the slices sign-extend them
	assign dx = pix.offset_x[COORD_WIDTH-1:0];
	assign dy = pix.offset_y[COORD_WIDTH-1:0];

	eapc_inside #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_inside (
		.clk    (clk),
		.adv    (adv),
		.cfg    (cfg_q),
		.dx     (dx),
		.dy     (dy),
		.ins_s3 (ins_s3)
	);

	eapc_sector #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_sector (
		.clk       (clk),
		.adv       (adv),
		.cfg       (cfg_q),
		.dx        (dx),
		.dy        (dy),
		.in_arc_s3 (in_arc_s3)
	);

	// Output register: border when inside with any neighbour outside
	always_ff @(posedge clk) begin
		if (rdy4) begin
			inside_s4 <= ins_s3[0];
			border_s4 <= ins_s3[0] && !(&ins_s3[4:1]);
			arc_s4    <= in_arc_s3;
		end
	end

	assign flags.valid      = v_s4;
	assign flags.inside_res = inside_s4;
	assign flags.on_border  = border_s4;
	assign flags.in_arc     = arc_s4;

	// An empty output register must never block the pixel channel
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |-> pix.ready)
		else $error("pixel channel stalled with empty output register");

	// An accepted pixel occupies the first stage on the next cycle
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready) |=> v_s1)
		else $error("accepted pixel missing from first stage");

	// A border pixel is always an inside pixel
	a_border_inside: assert property (@(posedge clk) disable iff (!arst_n)
		flags.valid |-> (!flags.on_border || flags.inside_res))
		else $error("border flag without inside flag");

	// A full pipeline with a stalled receiver refuses new pixels
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && !flags.ready) |-> !pix.ready)
		else $error("pixel accepted into a full stalled pipeline");

endmodule

`default_nettype wire

>>> bench/eapc_checker.sv
`timescale 1ns / 1ps
// Result checker for the ellipse arc pixel classifier: snoops register writes and both
// channels, predicts the three flags of every pixel and compares them in order.
// Depends on eapc_pkg, eapc_pix_if and eapc_flag_if.

module eapc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	eapc_pix_if                         pix,
	eapc_flag_if                        flags,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [eapc_pkg::APB_AW-1:0] paddr,
	input  logic [eapc_pkg::APB_DW-1:0] pwdata,
	output int                          errors,
	output int                          outstanding,
	output int                          checked,
	output int                          inside_seen,
	output int                          border_seen,
	output int                          arc_seen
);
	import eapc_pkg::*;

	typedef struct packed {
		logic inside_res;
		logic on_border;
		logic in_arc;
	} flags_t;

	typedef struct {
		logic signed [OFFSET_W-1:0] x;
		logic signed [OFFSET_W-1:0] y;
		flags_t                     f;
	} pixel_flags_t;

	// Direction in math orientation, y up
	typedef struct {
		longint x;
		longint y;
	} heading_t;

	cfg_t         shadow;
	pixel_flags_t pending_flags[$];
	int           fail_cnt, n_checked, n_inside, n_border, n_arc;

	// Exact membership: dx^2*ry^2 + dy^2*rx^2 <= rx^2*ry^2, degenerate radii as segments
	function automatic bit within_ellipse(longint dx, longint dy);
		longint unsigned ax, ay, rx, ry;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		rx = shadow.radius_x;
		ry = shadow.radius_y;
		if (rx == 0 && ry == 0)
			return ax == 0 && ay == 0;
		if (rx == 0)
			return ax == 0 && ay <= ry;
		if (ry == 0)
			return ay == 0 && ax <= rx;
		return ax * ax * ry * ry + ay * ay * rx * rx <= rx * rx * ry * ry;
	endfunction

	// Flip screen y; a null vector points along +x
	function automatic heading_t heading(longint dx, longint dy);
		heading_t v;
		v.x = dx;
		v.y = -dy;
		if (v.x == 0 && v.y == 0)
			v.x = 1;
		return v;
	endfunction

	function automatic longint wedge(heading_t a, heading_t b);
		return a.x * b.y - a.y * b.x;
	endfunction

	// Angle order from 0 up to 360 degrees: -1 when a comes first, 1 when b does
	function automatic int turn_order(heading_t a, heading_t b);
		int     ha, hb;
		longint c;
		ha = (a.y < 0 || (a.y == 0 && a.x < 0)) ? 1 : 0;
		hb = (b.y < 0 || (b.y == 0 && b.x < 0)) ? 1 : 0;
		if (ha != hb)
			return ha - hb;
		c = wedge(a, b);
		if (c > 0)
			return -1;
		if (c < 0)
			return 1;
		return 0;
	endfunction

	function automatic bit aligned(heading_t a, heading_t b);
		return wedge(a, b) == 0 && (a.x * b.x + a.y * b.y) > 0;
	endfunction

	function automatic bit in_sector(longint dx, longint dy);
		heading_t s, e, p;
		bit       same;
		bit       centre;
		if (shadow.arc_mode != MODE_ARC_FULL && shadow.arc_mode != MODE_ARC_RAY)
			return 1'b1;
		s = heading(longint'($signed(shadow.start_dx)), longint'($signed(shadow.start_dy)));
		e = heading(longint'($signed(shadow.end_dx)), longint'($signed(shadow.end_dy)));
		same = aligned(s, e);
		centre = (dx == 0 && dy == 0);
		if (same && shadow.arc_mode == MODE_ARC_FULL)
			return 1'b1;
		// Single ray: open half-line along the start direction
		if (same)
			return !centre && aligned(s, heading(dx, dy));
		if (centre)
			return 1'b1;
		p = heading(dx, dy);
		if (turn_order(s, e) <= 0)
			return turn_order(s, p) <= 0 && turn_order(p, e) <= 0;
		// Sector wraps through zero degrees
		return turn_order(s, p) <= 0 || turn_order(p, e) <= 0;
	endfunction

	function automatic flags_t classify(longint dx, longint dy);
		flags_t r;
		r.inside_res = within_ellipse(dx, dy);
		r.on_border  = r.inside_res && (!within_ellipse(dx - 1, dy) ||
			!within_ellipse(dx + 1, dy) || !within_ellipse(dx, dy - 1) ||
			!within_ellipse(dx, dy + 1));
		r.in_arc     = in_sector(dx, dy);
		return r;
	endfunction

	always @(posedge clk) begin : watch
		pixel_flags_t want;
		flags_t       got;
		if (!arst_n) begin
			shadow = '0;
			pending_flags.delete();
		end else begin
			// Track register writes; spare indexes are dropped
			if (psel && penable && pwrite && pready) begin
				case (paddr[APB_AW-1:2])
					REG_RADIUS_X: shadow.radius_x = pwdata[RADIUS_W-1:0];
					REG_RADIUS_Y: shadow.radius_y = pwdata[RADIUS_W-1:0];
					REG_START_DX: shadow.start_dx = pwdata[DIR_W-1:0];
					REG_START_DY: shadow.start_dy = pwdata[DIR_W-1:0];
					REG_END_DX:   shadow.end_dx   = pwdata[DIR_W-1:0];
					REG_END_DY:   shadow.end_dy   = pwdata[DIR_W-1:0];
					REG_ARC_MODE: shadow.arc_mode = pwdata[MODE_W-1:0];
					default: ;
				endcase
			end

			// Predict each pixel transfer
			if (pix.valid && pix.ready) begin
				want.x = pix.offset_x;
				want.y = pix.offset_y;
				want.f = classify(longint'(pix.offset_x), longint'(pix.offset_y));
				pending_flags.push_back(want);
			end

			// Compare each flag transfer with the oldest prediction
			if (flags.valid && flags.ready) begin
				got = {flags.inside_res, flags.on_border, flags.in_arc};
				if (pending_flags.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("%0t: flags %b arrived with no pixel pending", $realtime, got);
				end else begin
					want = pending_flags.pop_front();
					n_checked++;
					n_inside += want.f.inside_res;
					n_border += want.f.on_border;
					n_arc    += want.f.in_arc;
					if (got.inside_res !== want.f.inside_res ||
							got.on_border !== want.f.on_border ||
							got.in_arc !== want.f.in_arc) begin
						fail_cnt++;
						// Flags print in the order inside, border, arc
						if (fail_cnt <= 10)
							$display("%0t: (%0d,%0d) expected %b%b%b, got %b%b%b",
								$realtime, want.x, want.y,
								want.f.inside_res, want.f.on_border, want.f.in_arc,
								got.inside_res, got.on_border, got.in_arc);
					end
				end
			end
		end
		errors      <= fail_cnt;
		outstanding <= pending_flags.size();
		checked     <= n_checked;
		inside_seen <= n_inside;
		border_seen <= n_border;
		arc_seen    <= n_arc;
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the ellipse arc pixel classifier: clock, reset, register writes,
// pixel stimulus, receiver stalls and the verdict. Depends on eapc_pkg, both
// channel interfaces, the classifier top level and eapc_checker.

module tb_top;
	import eapc_pkg::*;

	localparam int                CYCLE_LIMIT  = 400000;
	localparam int                RANDOM_ITEMS = 1850;
	localparam int                HOLD_CYCLES  = 300;
	localparam logic [IDX_W-1:0]  SPARE_IDX    = 3'd7;
	localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;

	int errors, outstanding, checked, inside_seen, border_seen, arc_seen;
	int cur_rx, cur_ry, cur_sx, cur_sy, cur_ex, cur_ey;
	int settings_used, pixels_sent, cycle_count;
	int hold_requests, holds_done, hold_left, run_left;
	bit rcv_lazy, run_level;

	eapc_pix_if  pix_ch ();
	eapc_flag_if flag_ch ();

	ellipse_arc_pixel_classifier_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix_ch),
		.flags   (flag_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	eapc_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix         (pix_ch),
		.flags       (flag_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.inside_seen (inside_seen),
		.border_seen (border_seen),
		.arc_seen    (arc_seen)
	);

	always #4 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				outstanding);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: long hold-offs on request, otherwise random ready/stall runs
	initial begin
		flag_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_done != hold_requests) begin
				hold_left = HOLD_CYCLES;
				holds_done++;
			end
			if (hold_left != 0) begin
				hold_left--;
				flag_ch.ready <= 1'b0;
			end else if (!rcv_lazy) begin
				flag_ch.ready <= 1'b1;
			end else begin
				if (run_left == 0) begin
					run_level = $urandom_range(0, 2) != 0;
					run_left  = run_level ? $urandom_range(1, 16) : $urandom_range(1, 6);
				end
				run_left--;
				flag_ch.ready <= run_level;
			end
		end
	end

	// Two-phase register write that leaves the bus idle afterwards
	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Write all registers, sometimes with garbage above each field
	task automatic set_config(input int rx, ry, sx, sy, ex, ey, input logic [MODE_W-1:0] mode);
		logic [APB_DW-1:0] junk;
		junk   = ($urandom_range(0, 1) != 0) ? $urandom() : '0;
		cur_rx = rx;
		cur_ry = ry;
		cur_sx = sx;
		cur_sy = sy;
		cur_ex = ex;
		cur_ey = ey;
		cfg_write(REG_RADIUS_X, (junk & ~32'h7FFF) | (rx & 32'h7FFF));
		cfg_write(REG_RADIUS_Y, (junk & ~32'h7FFF) | (ry & 32'h7FFF));
		cfg_write(REG_START_DX, (junk & ~32'h1FFFF) | (sx & 32'h1FFFF));
		cfg_write(REG_START_DY, (junk & ~32'h1FFFF) | (sy & 32'h1FFFF));
		cfg_write(REG_END_DX, (junk & ~32'h1FFFF) | (ex & 32'h1FFFF));
		cfg_write(REG_END_DY, (junk & ~32'h1FFFF) | (ey & 32'h1FFFF));
		cfg_write(REG_ARC_MODE, (junk & ~32'h3) | mode);
		settings_used++;
	endtask

	// Offer one pixel and hold it until the transfer
	task automatic push_pixel(input int x, y);
		pix_ch.valid    <= 1'b1;
		pix_ch.offset_x <= x[OFFSET_W-1:0];
		pix_ch.offset_y <= y[OFFSET_W-1:0];
		do @(posedge clk); while (!pix_ch.ready);
		pixels_sent++;
	endtask

	// Stop sending and wait for every pending result
	task automatic drain();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic int clamp16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return int'(v);
	endfunction

	function automatic int pick_radius();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 32767;
			2: return $urandom_range(0, 32767);
			default: return $urandom_range(1, 60);
		endcase
	endfunction

	function automatic int pick_component();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 65535;
			2: return -65535;
			3: return int'($urandom_range(0, 131070)) - 65535;
			default: return int'($urandom_range(0, 40)) - 20;
		endcase
	endfunction

	// Pixels near the ellipse edge, on the arc rays, around the centre, or anywhere
	function automatic void pick_pixel(output int x, output int y);
		int     kind, ux, uy, a, b, t, k, kmax, span;
		longint px, py;
		real    q, r;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2, 3: begin
				if (cur_rx == 0)
					px = int'($urandom_range(0, 2)) - 1;
				else
					px = $urandom_range(0, cur_rx + 2);
				if (cur_rx == 0 || px >= cur_rx) begin
					r = 0.0;
				end else begin
					q = real'(px) / cur_rx;
					r = cur_ry * $sqrt(1.0 - q * q);
				end
				py = longint'(r) + int'($urandom_range(0, 4)) - 2;
				if ($urandom_range(0, 1) != 0)
					px = -px;
				if ($urandom_range(0, 1) != 0)
					py = -py;
			end
			4, 5: begin
				ux = (kind == 4) ? cur_sx : cur_ex;
				uy = (kind == 4) ? cur_sy : cur_ey;
				if (ux == 0 && uy == 0)
					ux = 1;
				// Reduce to the smallest lattice step along the direction
				a = (ux < 0) ? -ux : ux;
				b = (uy < 0) ? -uy : uy;
				while (b != 0) begin
					t = a % b;
					a = b;
					b = t;
				end
				ux = ux / a;
				uy = uy / a;
				span = ((ux < 0) ? -ux : ux) > ((uy < 0) ? -uy : uy) ?
					((ux < 0) ? -ux : ux) : ((uy < 0) ? -uy : uy);
				kmax = 32767 / span;
				if (kmax < 1)
					kmax = 1;
				if ($urandom_range(0, 1) != 0)
					k = $urandom_range(1, (kmax < 4) ? kmax : 4);
				else
					k = $urandom_range(1, kmax);
				if ($urandom_range(0, 5) == 0)
					k = -k;
				px = longint'(ux) * k;
				py = longint'(uy) * k;
			end
			6: begin
				px = int'($urandom_range(0, 6)) - 3;
				py = int'($urandom_range(0, 6)) - 3;
			end
			default: begin
				px = int'($urandom_range(0, 65535)) - 32768;
				py = int'($urandom_range(0, 65535)) - 32768;
			end
		endcase
		x = clamp16(px);
		y = clamp16(py);
	endfunction

	// Send n pixels, optionally in bursts, and request a long hold-off at one item
	task automatic send_pixels(input int n, input bit bursty, input int hold_at);
		int x, y, burst_left;
		burst_left = $urandom_range(1, 30);
		for (int i = 0; i < n; i++) begin
			if (i == hold_at)
				hold_requests++;
			pick_pixel(x, y);
			push_pixel(x, y);
			if (bursty) begin
				burst_left--;
				if (burst_left == 0) begin
					pix_ch.valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(posedge clk);
					burst_left = $urandom_range(1, 30);
				end
			end
		end
	endtask

	initial begin
		int  n, phase, goal, sx, sy, ex, ey;
		bit  fits;
		pix_ch.valid    <= 1'b0;
		pix_ch.offset_x <= '0;
		pix_ch.offset_y <= '0;
		psel            <= 1'b0;
		penable         <= 1'b0;
		pwrite          <= 1'b0;
		paddr           <= '0;
		pwdata          <= '0;
		rcv_lazy         = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset state: both radii zero, only the centre is inside
		push_pixel(0, 0);
		push_pixel(1, 0);
		push_pixel(-32768, -32768);
		push_pixel(32767, 32767);

		// Vertical segment, zero start and end vectors mean the full ellipse
		drain();
		set_config(0, 5, 0, 0, 0, 0, MODE_ARC_FULL);
		push_pixel(0, 5);
		push_pixel(0, -5);
		push_pixel(0, 6);
		push_pixel(1, 0);

		// Horizontal segment, single ray along +x, centre excluded
		drain();
		set_config(7, 0, 0, 0, 5, 0, MODE_ARC_RAY);
		push_pixel(0, 0);
		push_pixel(3, 0);
		push_pixel(-3, 0);
		push_pixel(7, 0);

		// Largest ellipse, sector wrapping from straight up through zero
		drain();
		set_config(32767, 32767, 0, -1, 1, 0, MODE_ARC_FULL);
		cfg_write(SPARE_IDX, $urandom());
		push_pixel(32767, 0);
		push_pixel(-32768, -32768);
		push_pixel(0, 0);
		push_pixel(32767, -32767);
		push_pixel(-32768, 32767);

		// Spare mode code behaves as the whole ellipse
		drain();
		set_config(32767, 1, -65535, 65535, 65535, -65535, MODE_SPARE);
		push_pixel(32767, 0);
		push_pixel(0, 1);
		push_pixel(-32768, -1);

		// Opposite directions in ray mode: upper half plane
		drain();
		set_config(3, 4, 1, 0, -1, 0, MODE_ARC_RAY);
		push_pixel(2, -2);
		push_pixel(2, 2);
		push_pixel(-3, 0);
		push_pixel(3, 0);

		// Random settings, each phase ends with the sender idle until all flags are in
		goal  = pixels_sent + RANDOM_ITEMS;
		phase = 0;
		while (pixels_sent < goal) begin
			drain();
			sx = pick_component();
			sy = pick_component();
			fits = sx <= 32767 && sx >= -32767 && sy <= 32767 && sy >= -32767;
			case ($urandom_range(0, 5))
				0: begin
					ex = sx;
					ey = sy;
				end
				1: begin
					ex = fits ? 2 * sx : sx;
					ey = fits ? 2 * sy : sy;
				end
				2: begin
					ex = -sx;
					ey = -sy;
				end
				default: begin
					ex = pick_component();
					ey = pick_component();
				end
			endcase
			set_config(pick_radius(), pick_radius(), sx, sy, ex, ey,
				MODE_W'($urandom_range(0, 3)));
			rcv_lazy = (phase % 3 != 0);
			n = $urandom_range(100, 200);
			send_pixels(n, phase % 3 == 2, (phase == 1 || phase == 5) ? 20 : -1);
			phase++;
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Checked %0d pixel results under %0d register settings, %0d long hold-offs",
			checked, settings_used, holds_done);
		$display("Predicted flags: %0d inside, %0d on the border, %0d in the arc sector",
			inside_seen, border_seen, arc_seen);
		if (errors == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
